/* sv/ort_pkg.sv */
`timescale 1ns / 1ps

package ort_pkg;

	localparam int ENTRIES_DEF = 16;

	localparam logic [1:0] FUNC_ADD  = 2'd0;
	localparam logic [1:0] FUNC_DEL  = 2'd1;
	localparam logic [1:0] FUNC_LOOK = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOROUTE = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_DEL,
		OP_LOOK,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_RESP
	} back_state_t;

	// one route: destination, mask, gateway, interface
	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gw;
		logic [3:0]  iface;
	} entry_t;

	// classified command; for lookup the address rides in route.dest
	typedef struct packed {
		op_t    op;
		entry_t route;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic       used_default;
		entry_t     route;
		logic [4:0] removed;
	} res_t;

endpackage

/* sv/ort_front.sv */
`timescale 1ns / 1ps

module ort_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    func,
	input  logic [31:0]   dest_addr,
	input  logic [31:0]   net_mask,
	input  logic [31:0]   gateway_addr,
	input  logic [3:0]    iface_id,
	input  logic [31:0]   query_addr,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output ort_pkg::cmd_t cmd
);

	ort_pkg::cmd_t q_mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;
	ort_pkg::cmd_t cls;

	// classify: map func to an operation, steer the lookup address into dest
	always_comb begin
		cls = '0;
		case (func)
			ort_pkg::FUNC_ADD: begin
				cls.op          = ort_pkg::OP_ADD;
				cls.route.dest  = dest_addr;
				cls.route.mask  = net_mask;
				cls.route.gw    = gateway_addr;
				cls.route.iface = iface_id;
			end
			ort_pkg::FUNC_DEL: begin
				cls.op          = ort_pkg::OP_DEL;
				cls.route.dest  = dest_addr;
				cls.route.mask  = net_mask;
				cls.route.gw    = gateway_addr;
				cls.route.iface = iface_id;
			end
			ort_pkg::FUNC_LOOK: begin
				cls.op         = ort_pkg::OP_LOOK;
				cls.route.dest = query_addr;
			end
			default: begin
				cls.op = ort_pkg::OP_NOP;
			end
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cls;
	end

endmodule

/* sv/ort_back.sv */
`timescale 1ns / 1ps

module ort_back #(
	parameter int ENTRIES = ort_pkg::ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ort_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output ort_pkg::res_t res
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = $clog2(ENTRIES);

	ort_pkg::entry_t mem [ENTRIES];

	ort_pkg::back_state_t state_q, state_d;
	ort_pkg::cmd_t        cmd_q, cmd_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0]     kept_q, kept_d;
	logic [CNT_W-1:0]     removed_q, removed_d;
	logic                 chk_vld_s1, chk_vld_d;
	ort_pkg::entry_t      rdata_s1;
	logic                 have_def_q, have_def_d;
	ort_pkg::entry_t      def_q, def_d;
	ort_pkg::res_t        res_q, res_d;
	logic                 out_vld_q, out_vld_d;
	ort_pkg::res_t        out_res_q, out_res_d;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	ort_pkg::entry_t      mem_wdata;
	logic                 mem_re;
	logic [IDX_W-1:0]     mem_raddr;
	logic [CNT_W+4:0]     rem_wide;

	assign cmd_ready = (state_q == ort_pkg::B_IDLE);
	assign out_valid = out_vld_q;
	assign res       = out_res_q;
	assign rem_wide  = (CNT_W + 5)'(removed_q);

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		count_d    = count_q;
		rd_idx_d   = rd_idx_q;
		kept_d     = kept_q;
		removed_d  = removed_q;
		chk_vld_d  = 1'b0;
		have_def_d = have_def_q;
		def_d      = def_q;
		res_d      = res_q;
		out_vld_d  = out_vld_q;
		out_res_d  = out_res_q;
		mem_we     = 1'b0;
		mem_waddr  = count_q[IDX_W-1:0];
		mem_wdata  = cmd.route;
		mem_re     = 1'b0;
		mem_raddr  = rd_idx_q[IDX_W-1:0];

		if (out_vld_q && out_ready)
			out_vld_d = 1'b0;

		case (state_q)
			ort_pkg::B_IDLE: begin
				if (cmd_valid) begin
					cmd_d      = cmd;
					rd_idx_d   = '0;
					kept_d     = '0;
					removed_d  = '0;
					have_def_d = 1'b0;
					res_d      = '0;
					case (cmd.op)
						ort_pkg::OP_ADD: begin
							if (count_q == CNT_W'(ENTRIES)) begin
								res_d.status = ort_pkg::ST_FULL;
							end else begin
								mem_we      = 1'b1;
								count_d     = count_q + CNT_W'(1);
								res_d.route = cmd.route;
							end
							state_d = ort_pkg::B_RESP;
						end
						ort_pkg::OP_DEL,
						ort_pkg::OP_LOOK: begin
							state_d = ort_pkg::B_SCAN;
						end
						default: begin
							state_d = ort_pkg::B_RESP;
						end
					endcase
				end
			end
			ort_pkg::B_SCAN: begin
				// check the entry read last cycle
				if (chk_vld_s1 && cmd_q.op == ort_pkg::OP_DEL) begin
					if (rdata_s1 == cmd_q.route) begin
						removed_d = removed_q + CNT_W'(1);
					end else begin
						mem_we    = 1'b1;
						mem_waddr = kept_q[IDX_W-1:0];
						mem_wdata = rdata_s1;
						kept_d    = kept_q + CNT_W'(1);
					end
				end
				if (chk_vld_s1 && cmd_q.op == ort_pkg::OP_LOOK &&
				    rdata_s1.dest == 32'd0) begin
					have_def_d = 1'b1;
					def_d      = rdata_s1;
				end

				if (chk_vld_s1 && cmd_q.op == ort_pkg::OP_LOOK &&
				    rdata_s1.dest != 32'd0 &&
				    (cmd_q.route.dest & rdata_s1.mask) == rdata_s1.dest) begin
					res_d.route = rdata_s1;
					state_d     = ort_pkg::B_RESP;
				end else if (rd_idx_q != count_q) begin
					mem_re    = 1'b1;
					rd_idx_d  = rd_idx_q + CNT_W'(1);
					chk_vld_d = 1'b1;
				end else if (!chk_vld_s1) begin
					if (cmd_q.op == ort_pkg::OP_DEL) begin
						count_d       = kept_q;
						res_d.removed = (rem_wide > (CNT_W + 5)'(31)) ? 5'd31 : rem_wide[4:0];
					end else if (have_def_q) begin
						res_d.route        = def_q;
						res_d.used_default = 1'b1;
					end else begin
						res_d.status = ort_pkg::ST_NOROUTE;
					end
					state_d = ort_pkg::B_RESP;
				end
			end
			ort_pkg::B_RESP: begin
				if (!out_vld_q || out_ready) begin
					out_vld_d = 1'b1;
					out_res_d = res_q;
					state_d   = ort_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = ort_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ort_pkg::B_IDLE;
			count_q    <= '0;
			chk_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
			have_def_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			chk_vld_s1 <= chk_vld_d;
			out_vld_q  <= out_vld_d;
			have_def_q <= have_def_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		rd_idx_q  <= rd_idx_d;
		kept_q    <= kept_d;
		removed_q <= removed_d;
		def_q     <= def_d;
		res_q     <= res_d;
		out_res_q <= out_res_d;
	end

	// route store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_s1 <= mem[mem_raddr];
	end

endmodule

/* sv/ordered_route_table.sv */
`timescale 1ns / 1ps

// Ordered IPv4 route table, first match wins, with a default route.
// Input channel in_valid/in_ready carries one transaction: func selects
// add, delete or lookup; the route fields serve add and delete, query_addr
// serves lookup. Output channel out_valid/out_ready returns exactly one
// result transaction per input, in input order.
// Add and unused codes go from idle straight to the response state, which
// registers the result and raises out_valid; delete and lookup first pass
// through the scan state, whose length grows with the number of stored
// routes, since the back end reads the route store one entry per cycle
// through its single registered read port (a lookup hit stops early).
// Only one transaction is in the back end at a time: it takes a new command
// only after the current one has moved its result to the output register.
// A two-entry command queue keeps in_ready high while not full, also while
// the back end works or the output waits. When the receiver holds out_ready
// low, hold the result in the output register; the back end stalls once it
// has its next result, then the queue fills and in_ready drops.
// Reset empties the table and the queue; stored routes need no clearing.
module ordered_route_table #(
	parameter int ENTRIES = ort_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] dest_addr,
	input  logic [31:0] net_mask,
	input  logic [31:0] gateway_addr,
	input  logic [3:0]  iface_id,
	input  logic [31:0] query_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        used_default,
	output logic [31:0] out_dest,
	output logic [31:0] out_mask,
	output logic [31:0] out_gateway,
	output logic [3:0]  out_iface,
	output logic [4:0]  removed_count
);

	ort_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_ready;
	ort_pkg::res_t res;

	// front: accept and classify, queue the command
	ort_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.dest_addr    (dest_addr),
		.net_mask     (net_mask),
		.gateway_addr (gateway_addr),
		.iface_id     (iface_id),
		.query_addr   (query_addr),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	// back: own the route store, scan it, register the result
	ort_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// unpack the result transaction onto the ports
	assign status        = res.status;
	assign used_default  = res.used_default;
	assign out_dest      = res.route.dest;
	assign out_mask      = res.route.mask;
	assign out_gateway   = res.route.gw;
	assign out_iface     = res.route.iface;
	assign removed_count = res.removed;

endmodule
